>>> rtl/core/urzt_pkg.sv
// Package for the ultrasonic range zone trigger: phase and action codes,
// register indexes, timing and distance scaling constants.
// No dependencies; imported by ultrasonic_range_zone_trigger.
package urzt_pkg;

    // Sizes and limits
    localparam int NUM_ZONES  = 6;
    localparam int NUM_BOUNDS = NUM_ZONES + 1;
    localparam int CNT_W      = 16;
    localparam int DIST_W     = 17;
    localparam int ZONE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CNT_W-1:0] LOW_TICKS  = 16'd2;
    localparam logic [CNT_W-1:0] HIGH_TICKS = 16'd10;
    localparam logic [CNT_W-1:0] COUNT_MAX  = 16'hFFFF;

    // Distance = floor(count * 17 / 10), done as a multiply by a rounded-up
    // reciprocal and a shift; exact for any 16-bit count.
    localparam int DIST_SHIFT = 20;
    localparam int MULT_W     = 21;
    localparam logic [MULT_W-1:0] DIST_MULT = 21'd1782580;
    localparam int PROD_W     = CNT_W + MULT_W;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_0 = 3'd1;

    localparam logic [ZONE_W-1:0] ZONE_NONE = 3'd0;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH,
        PH_WAIT,
        PH_ECHO
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PLAY,
        ACT_STOP
    } action_t;

    // Per-beat status carried down the pipeline
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
    } ctl_t;

endpackage

>>> rtl/core/ultrasonic_range_zone_trigger.sv
// Ultrasonic echo ranging with distance zones: sequencer, distance scaling,
// zone lookup and play/stop decision in a three-register pipeline.
// Depends on urzt_pkg.

// Each input beat is one microsecond tick carrying a start request and the
// sampled echo level; each accepted beat yields exactly one result beat. The
// block takes one tick per clock cycle while the pipeline is not held. A
// tick's result is registered in turn: the accepting edge loads the sequencer
// and first stage, then the distance multiply register is loaded, then the
// zone compare result register. The pipeline is held only while
// m_axis_tready is low.
// A start seen while idle drives the trigger low for two ticks (the start
// tick being the first) and high for ten, then waits for the echo to rise
// and counts echo-high ticks up to 65535. On the first low echo tick the
// result carries done, the distance in hundredths of a centimetre
// (count*17/10, truncated), the first matching zone and the play/stop action
// compared with the zone last reported. Write configuration only while idle.
module ultrasonic_range_zone_trigger
    import urzt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Tick input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [0] start_req, [1] echo_level
    // Result output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] trigger_level, [1] busy_res, [2] done_res, [19:3] distance,
    // [22:20] zone, [24:23] action
    output logic [31:0]           m_axis_tdata
);

    // Configuration registers
    logic [ZONE_W-1:0] zone_count_reg;
    logic [DIST_W-1:0] boundary_reg [NUM_BOUNDS];
    logic [CFG_IDX_W-1:0] bound_idx;

    // Sequencer state
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  tick_count_reg, tick_count_next;
    ctl_t              seq_ctl;
    logic [CNT_W-1:0]  seq_count;

    // Pipeline
    logic              s1_valid_reg, s2_valid_reg, m_valid_reg;
    ctl_t              s1_ctl_reg, s2_ctl_reg, m_ctl_reg;
    logic [CNT_W-1:0]  s1_count_reg;
    logic [DIST_W-1:0] s2_dist_reg, m_dist_reg;
    logic [ZONE_W-1:0] m_zone_reg;
    action_t           m_action_reg;
    logic [PROD_W-1:0] dist_prod;
    logic              out_ready, s2_ready, s1_ready, s_fire;

    // Zone lookup and decision
    logic [ZONE_W-1:0] zone_lim;
    logic [ZONE_W-1:0] zone_hit;
    logic [ZONE_W-1:0] last_zone_reg, last_zone_next;
    action_t           action_next;
    logic              start_req, echo_level;

    assign start_req  = s_axis_tdata[0];
    assign echo_level = s_axis_tdata[1];

    // Handshake: each stage advances when the one after it has room
    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign s_fire        = s_axis_tvalid && s1_ready;

    // Configuration writes
    assign bound_idx = cfg_index - REG_BOUNDARY_0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_count_reg <= 3'd1;
            for (int i = 0; i < NUM_BOUNDS; i++) begin
                boundary_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ZONE_COUNT: zone_count_reg <= cfg_wdata[ZONE_W-1:0];
                default:        boundary_reg[bound_idx] <= cfg_wdata;
            endcase
        end
    end

    // Sequencer: next phase, counter and per-tick status
    always_comb begin
        phase_t ph;
        ph              = phase_reg;
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        seq_ctl         = '0;
        seq_count       = tick_count_reg;
        if (phase_reg == PH_IDLE && start_req) begin
            ph              = PH_LOW;
            tick_count_next = '0;
        end
        case (ph)
            PH_IDLE: begin
                phase_next = PH_IDLE;
            end
            PH_LOW: begin
                seq_ctl.busy    = 1'b1;
                tick_count_next = tick_count_next + 16'd1;
                phase_next      = PH_LOW;
                if (tick_count_next >= LOW_TICKS) begin
                    phase_next      = PH_HIGH;
                    tick_count_next = '0;
                end
            end
            PH_HIGH: begin
                seq_ctl.busy    = 1'b1;
                seq_ctl.trig    = 1'b1;
                tick_count_next = tick_count_reg + 16'd1;
                if (tick_count_next >= HIGH_TICKS) begin
                    phase_next      = PH_WAIT;
                    tick_count_next = '0;
                end
            end
            PH_WAIT: begin
                seq_ctl.busy = 1'b1;
                if (echo_level) begin
                    phase_next      = PH_ECHO;
                    tick_count_next = 16'd1;
                end
            end
            PH_ECHO: begin
                seq_ctl.busy = 1'b1;
                if (echo_level) begin
                    if (tick_count_reg != COUNT_MAX) begin
                        tick_count_next = tick_count_reg + 16'd1;
                    end
                end else begin
                    seq_ctl.done    = 1'b1;
                    phase_next      = PH_IDLE;
                    tick_count_next = '0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Advance sequencer state on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
        end else if (s_fire) begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
        end
    end

    // Scale the echo count to distance
    assign dist_prod = PROD_W'(s1_count_reg) * PROD_W'(DIST_MULT);

    // Zone lookup: lowest matching zone wins
    assign zone_lim = (zone_count_reg > ZONE_W'(NUM_ZONES)) ? ZONE_W'(NUM_ZONES)
                                                           : zone_count_reg;

    always_comb begin
        zone_hit = ZONE_NONE;
        for (int i = NUM_ZONES - 1; i >= 0; i--) begin
            if (ZONE_W'(i) < zone_lim && boundary_reg[i] <= s2_dist_reg &&
                s2_dist_reg < boundary_reg[i+1]) begin
                zone_hit = ZONE_W'(i + 1);
            end
        end
    end

    // Play/stop decision against the zone last reported
    always_comb begin
        last_zone_next = last_zone_reg;
        action_next    = ACT_NONE;
        if (last_zone_reg == ZONE_NONE) begin
            last_zone_next = zone_hit;
            action_next    = (zone_hit != ZONE_NONE) ? ACT_PLAY : ACT_NONE;
        end else if (last_zone_reg != zone_hit) begin
            last_zone_next = zone_hit;
            action_next    = (zone_hit != ZONE_NONE) ? ACT_PLAY : ACT_STOP;
        end
    end

    // Pipeline valids and the stored zone
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            last_zone_reg <= ZONE_NONE;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= s2_valid_reg;
            end
            if (out_ready && s2_valid_reg && s2_ctl_reg.done) begin
                last_zone_reg <= last_zone_next;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_ctl_reg   <= seq_ctl;
            s1_count_reg <= seq_count;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_ctl_reg  <= s1_ctl_reg;
            s2_dist_reg <= s1_ctl_reg.done ? dist_prod[DIST_SHIFT +: DIST_W] : '0;
        end
        if (out_ready && s2_valid_reg) begin
            m_ctl_reg    <= s2_ctl_reg;
            m_dist_reg   <= s2_dist_reg;
            m_zone_reg   <= s2_ctl_reg.done ? zone_hit : ZONE_NONE;
            m_action_reg <= s2_ctl_reg.done ? action_next : ACT_NONE;
        end
    end

    // Output beat
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_action_reg, m_zone_reg, m_dist_reg,
                            m_ctl_reg.done, m_ctl_reg.busy, m_ctl_reg.trig};

    // Checks
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_ctl_reg.done |-> m_ctl_reg.busy && !m_ctl_reg.trig)
        else $error("done beat without busy or with trigger high");

    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ctl_reg.done |->
            m_dist_reg == '0 && m_zone_reg == ZONE_NONE && m_action_reg == ACT_NONE)
        else $error("result fields set on a beat without done");

    a_zone_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_zone_reg <= ZONE_W'(NUM_ZONES) &&
                        last_zone_reg <= ZONE_W'(NUM_ZONES))
        else $error("zone beyond the zone count");

    a_low_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LOW |-> tick_count_reg < LOW_TICKS)
        else $error("trigger low phase overran");

    a_stop_only_from_zone: assert property (@(posedge aclk) disable iff (!aresetn)
        out_ready && s2_valid_reg && s2_ctl_reg.done && last_zone_reg == ZONE_NONE
        |=> m_action_reg != ACT_STOP)
        else $error("stop issued with no zone playing");

endmodule
